[design/ldb_pkg.sv]
package ldb_pkg;

  localparam int COORD_W         = 12;
  localparam int LINE_BYTES_W    = 13;
  localparam int CFG_INDEX_W     = 1;
  localparam int BYTES_PER_PIXEL_DEF = 2;
  localparam int SLOT_COUNT_DEF      = 2;

  localparam logic [COORD_W-1:0] SCREEN_W_RESET = 12'd320;
  localparam logic [COORD_W-1:0] SCREEN_H_RESET = 12'd240;

  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_W = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_H = 1'b1;

  typedef enum logic [2:0] {
    CMD_INIT    = 3'd0,
    CMD_ACQUIRE = 3'd1,
    CMD_COMMIT  = 3'd2,
    CMD_CANCEL  = 3'd3,
    CMD_SERVICE = 3'd4,
    CMD_CLR_ERR = 3'd5
  } command_t;

  typedef enum logic [1:0] {
    DMA_BUSY = 2'd0,
    DMA_DONE = 2'd1,
    DMA_FAIL = 2'd2,
    DMA_RSVD = 2'd3
  } dma_status_t;

  typedef enum logic [1:0] {
    SLOT_FREE    = 2'd0,
    SLOT_FILLING = 2'd1,
    SLOT_READY   = 2'd2,
    SLOT_TX      = 2'd3
  } slot_state_t;

  typedef enum logic {
    CTL_EMPTY = 1'b0,
    CTL_FULL  = 1'b1
  } ctl_state_t;

  typedef struct packed {
    logic [2:0]         command;
    logic               slot;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] width;
    logic [1:0]         dma_status;
    logic               start_ok;
  } in_item_t;

  typedef struct packed {
    logic                    ok;
    logic                    granted_slot;
    logic                    start_request;
    logic [COORD_W-1:0]      start_x;
    logic [COORD_W-1:0]      start_y;
    logic [COORD_W-1:0]      start_width;
    logic [LINE_BYTES_W-1:0] line_bytes;
    logic                    start_slot;
    logic                    error_flag;
    logic                    transfer_active;
  } out_item_t;

  // exec and at most one op strobe, high only when an item is taken
  typedef struct packed {
    logic exec;
    logic op_init;
    logic op_acquire;
    logic op_commit;
    logic op_cancel;
    logic op_service;
    logic op_clr_err;
  } ldb_cmd_t;

endpackage

[design/ldb_ctrl.sv]
module ldb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [2:0]       in_command,
  input  logic             out_ready,
  output logic             in_ready,
  output logic             out_valid,
  output ldb_pkg::ldb_cmd_t cmd
);
  import ldb_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CTL_EMPTY: begin
        if (in_valid) state_nxt = CTL_FULL;
      end
      CTL_FULL: begin
        if (out_ready && !in_valid) state_nxt = CTL_EMPTY;
      end
      default: state_nxt = CTL_EMPTY;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == CTL_EMPTY) || out_ready;
    out_valid = (state_r == CTL_FULL);
    cmd       = '0;
    cmd.exec  = accept;
    case (in_command)
      CMD_INIT:    cmd.op_init    = accept;
      CMD_ACQUIRE: cmd.op_acquire = accept;
      CMD_COMMIT:  cmd.op_commit  = accept;
      CMD_CANCEL:  cmd.op_cancel  = accept;
      CMD_SERVICE: cmd.op_service = accept;
      CMD_CLR_ERR: cmd.op_clr_err = accept;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CTL_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/ldb_datapath.sv]
module ldb_datapath #(
  parameter int BYTES_PER_PIXEL = ldb_pkg::BYTES_PER_PIXEL_DEF,
  parameter int SLOT_COUNT      = ldb_pkg::SLOT_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ldb_pkg::ldb_cmd_t                 cmd,
  input  ldb_pkg::in_item_t                 item,
  input  logic                              cfg_we,
  input  logic [ldb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ldb_pkg::COORD_W-1:0]       cfg_data,
  output ldb_pkg::out_item_t                result
);
  import ldb_pkg::*;

  localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PROD_W = COORD_W + 3;

  slot_state_t        status_r   [SLOT_COUNT];
  slot_state_t        status_nxt [SLOT_COUNT];
  logic [COORD_W-1:0] col_r      [SLOT_COUNT];
  logic [COORD_W-1:0] row_r      [SLOT_COUNT];
  logic [COORD_W-1:0] pix_r      [SLOT_COUNT];
  logic               active_valid_r, active_valid_nxt;
  logic [IDX_W-1:0]   active_slot_r, active_slot_nxt;
  logic               error_r, error_nxt;
  logic [COORD_W-1:0] screen_w_r, screen_h_r;
  out_item_t          result_r, result_nxt;

  logic               busy;
  logic               win_we;
  logic               hit;
  logic [IDX_W-1:0]   pick;
  logic [IDX_W-1:0]   slot_idx;
  logic [PROD_W-1:0]  prod;

  assign busy     = (item.dma_status == DMA_BUSY) || (item.dma_status == DMA_RSVD);
  assign slot_idx = IDX_W'(item.slot);

  always_comb begin
    status_nxt       = status_r;
    active_valid_nxt = active_valid_r;
    active_slot_nxt  = active_slot_r;
    error_nxt        = error_r;
    result_nxt       = '0;
    win_we           = 1'b0;
    hit              = 1'b0;
    pick             = '0;
    prod             = '0;

    if (cmd.op_init) begin
      if (!(active_valid_r && busy)) begin
        for (int i = 0; i < SLOT_COUNT; i++) status_nxt[i] = SLOT_FREE;
        active_valid_nxt = 1'b0;
        active_slot_nxt  = '0;
        error_nxt        = 1'b0;
        result_nxt.ok    = 1'b1;
      end
    end else if (cmd.op_acquire) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (!hit && status_r[i] == SLOT_FREE) begin
          hit  = 1'b1;
          pick = IDX_W'(i);
        end
      end
      if (hit) begin
        status_nxt[pick]        = SLOT_FILLING;
        result_nxt.ok           = 1'b1;
        result_nxt.granted_slot = pick[0];
      end
    end else if (cmd.op_commit) begin
      if (status_r[slot_idx] == SLOT_FILLING && item.width != '0 &&
          item.width <= screen_w_r && item.x <= (screen_w_r - item.width) &&
          item.y < screen_h_r) begin
        win_we               = 1'b1;
        status_nxt[slot_idx] = SLOT_READY;
        result_nxt.ok        = 1'b1;
      end
    end else if (cmd.op_cancel) begin
      if (status_r[slot_idx] == SLOT_FILLING) begin
        status_nxt[slot_idx] = SLOT_FREE;
        result_nxt.ok        = 1'b1;
      end
    end else if (cmd.op_service) begin
      result_nxt.ok = 1'b1;
      // hold everything while the running transfer is still busy
      if (!(active_valid_r && busy)) begin
        if (active_valid_r) begin
          status_nxt[active_slot_r] = SLOT_FREE;
          active_valid_nxt          = 1'b0;
          active_slot_nxt           = '0;
          if (item.dma_status == DMA_FAIL) error_nxt = 1'b1;
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!hit && status_nxt[i] == SLOT_READY) begin
            hit  = 1'b1;
            pick = IDX_W'(i);
          end
        end
        if (hit) begin
          if (item.start_ok) begin
            status_nxt[pick]         = SLOT_TX;
            active_valid_nxt         = 1'b1;
            active_slot_nxt          = pick;
            prod                     = {3'b000, pix_r[pick]} * PROD_W'(BYTES_PER_PIXEL);
            result_nxt.start_request = 1'b1;
            result_nxt.start_x       = col_r[pick];
            result_nxt.start_y       = row_r[pick];
            result_nxt.start_width   = pix_r[pick];
            result_nxt.line_bytes    = prod[LINE_BYTES_W-1:0];
            result_nxt.start_slot    = pick[0];
          end else begin
            // drop the line and flag it
            status_nxt[pick] = SLOT_FREE;
            error_nxt        = 1'b1;
          end
        end
      end
    end else if (cmd.op_clr_err) begin
      error_nxt     = 1'b0;
      result_nxt.ok = 1'b1;
    end

    result_nxt.error_flag      = error_nxt;
    result_nxt.transfer_active = active_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) status_r[i] <= SLOT_FREE;
      active_valid_r <= 1'b0;
      active_slot_r  <= '0;
      error_r        <= 1'b0;
      screen_w_r     <= SCREEN_W_RESET;
      screen_h_r     <= SCREEN_H_RESET;
    end else begin
      if (cmd.exec) begin
        status_r       <= status_nxt;
        active_valid_r <= active_valid_nxt;
        active_slot_r  <= active_slot_nxt;
        error_r        <= error_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SCREEN_W: screen_w_r <= cfg_data;
          REG_SCREEN_H: screen_h_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      col_r[slot_idx] <= item.x;
      row_r[slot_idx] <= item.y;
      pix_r[slot_idx] <= item.width;
    end
    if (cmd.exec) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

[design/line_double_buffer_dma_manager.sv]
// Line slot manager for a ping-pong display line buffer.
// Input channel (in_valid/in_ready/in_item) carries one command per item:
// init, acquire, commit, cancel, service or clear error. Every accepted item
// gives exactly one result item on the output channel (out_valid/out_ready/
// out_item): ok flag, granted slot, the transfer window and byte count when a
// service step starts a line, and the sticky error and active transfer flags.
// The result is registered at the edge that accepts the item and shown from
// the next cycle. An item is taken every cycle as long as the receiver keeps
// up; the whole command is decoded and executed combinationally against the
// slot state registers.
// While a result waits, in_ready follows out_ready, so the next item is taken
// in the same cycle the held result leaves; a stalled receiver stalls input.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) writes screen width
// (index 0) or height (index 1); cfg_ready is always high.
// Synchronous reset: all slots free, no active transfer, error clear, screen
// 320 x 240, output channel empty. Stored windows are not cleared.
module line_double_buffer_dma_manager #(
  parameter int BYTES_PER_PIXEL = ldb_pkg::BYTES_PER_PIXEL_DEF,
  parameter int SLOT_COUNT      = ldb_pkg::SLOT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ldb_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ldb_pkg::out_item_t              out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ldb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ldb_pkg::COORD_W-1:0]     cfg_data
);
  import ldb_pkg::*;

  ldb_cmd_t cmd;
  logic     cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  ldb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_item.command),
    .out_ready  (out_ready),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .cmd        (cmd)
  );

  ldb_datapath #(
    .BYTES_PER_PIXEL (BYTES_PER_PIXEL),
    .SLOT_COUNT      (SLOT_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .item      (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (out_item)
  );

endmodule

[sim/line_cmd_checker.sv]
`timescale 1ns / 100ps

module line_cmd_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  ldb_pkg::in_item_t               in_item,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  ldb_pkg::out_item_t              out_item,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [ldb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ldb_pkg::COORD_W-1:0]     cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              checked,
  output int                              starts
);
  import ldb_pkg::*;

  localparam int MAX_REPORTS = 50;

  // shadow copy of the slot bookkeeping
  slot_state_t        slot_st  [SLOT_COUNT_DEF];
  logic [COORD_W-1:0] line_col [SLOT_COUNT_DEF];
  logic [COORD_W-1:0] line_row [SLOT_COUNT_DEF];
  logic [COORD_W-1:0] line_pix [SLOT_COUNT_DEF];
  logic               xfer_active;
  logic               xfer_slot;
  logic               err_sticky;
  logic [COORD_W-1:0] scr_w;
  logic [COORD_W-1:0] scr_h;

  out_item_t replies_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    starts     = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_REPORTS)
      $display("[%0t] result %0d: %s", $time, checked, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  function automatic out_item_t predict_line_cmd(input in_item_t it);
    out_item_t r;
    logic      busy;
    logic      found;
    logic      go;
    r     = '0;
    busy  = (it.dma_status == DMA_BUSY) || (it.dma_status == DMA_RSVD);
    found = 1'b0;
    go    = 1'b1;
    case (it.command)
      CMD_INIT: begin
        // refused while a transfer is still running
        if (!(xfer_active && busy)) begin
          for (int i = 0; i < SLOT_COUNT_DEF; i++) slot_st[i] = SLOT_FREE;
          xfer_active = 1'b0;
          xfer_slot   = 1'b0;
          err_sticky  = 1'b0;
          r.ok        = 1'b1;
        end
      end
      CMD_ACQUIRE: begin
        for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
          if (!found && slot_st[i] == SLOT_FREE) begin
            found          = 1'b1;
            slot_st[i]     = SLOT_FILLING;
            r.ok           = 1'b1;
            r.granted_slot = 1'(i);
          end
        end
      end
      CMD_COMMIT: begin
        if (slot_st[it.slot] == SLOT_FILLING && it.width != '0 && it.width <= scr_w &&
            int'(it.x) <= int'(scr_w) - int'(it.width) && it.y < scr_h) begin
          line_col[it.slot] = it.x;
          line_row[it.slot] = it.y;
          line_pix[it.slot] = it.width;
          slot_st[it.slot]  = SLOT_READY;
          r.ok              = 1'b1;
        end
      end
      CMD_CANCEL: begin
        if (slot_st[it.slot] == SLOT_FILLING) begin
          slot_st[it.slot] = SLOT_FREE;
          r.ok             = 1'b1;
        end
      end
      CMD_SERVICE: begin
        r.ok = 1'b1;
        if (xfer_active) begin
          if (busy) begin
            go = 1'b0;
          end else begin
            slot_st[xfer_slot] = SLOT_FREE;
            xfer_active        = 1'b0;
            xfer_slot          = 1'b0;
            if (it.dma_status == DMA_FAIL) err_sticky = 1'b1;
          end
        end
        if (go) begin
          for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
            if (!found && slot_st[i] == SLOT_READY) begin
              found = 1'b1;
              if (it.start_ok) begin
                slot_st[i]      = SLOT_TX;
                xfer_active     = 1'b1;
                xfer_slot       = 1'(i);
                r.start_request = 1'b1;
                r.start_x       = line_col[i];
                r.start_y       = line_row[i];
                r.start_width   = line_pix[i];
                r.line_bytes    = LINE_BYTES_W'(int'(line_pix[i]) * BYTES_PER_PIXEL_DEF);
                r.start_slot    = 1'(i);
              end else begin
                // failed start drops the line and flags it
                slot_st[i] = SLOT_FREE;
                err_sticky = 1'b1;
              end
            end
          end
        end
      end
      CMD_CLR_ERR: begin
        err_sticky = 1'b0;
        r.ok       = 1'b1;
      end
      default: ;
    endcase
    r.error_flag      = err_sticky;
    r.transfer_active = xfer_active;
    return r;
  endfunction

  task automatic compare_reply(input out_item_t got, input out_item_t want);
    check_field("ok", 32'(got.ok), 32'(want.ok));
    check_field("granted_slot", 32'(got.granted_slot), 32'(want.granted_slot));
    check_field("start_request", 32'(got.start_request), 32'(want.start_request));
    check_field("start_x", 32'(got.start_x), 32'(want.start_x));
    check_field("start_y", 32'(got.start_y), 32'(want.start_y));
    check_field("start_width", 32'(got.start_width), 32'(want.start_width));
    check_field("line_bytes", 32'(got.line_bytes), 32'(want.line_bytes));
    check_field("start_slot", 32'(got.start_slot), 32'(want.start_slot));
    check_field("error_flag", 32'(got.error_flag), 32'(want.error_flag));
    check_field("transfer_active", 32'(got.transfer_active), 32'(want.transfer_active));
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT_DEF; i++) slot_st[i] = SLOT_FREE;
      xfer_active = 1'b0;
      xfer_slot   = 1'b0;
      err_sticky  = 1'b0;
      scr_w       = SCREEN_W_RESET;
      scr_h       = SCREEN_H_RESET;
      replies_due.delete();
    end else begin
      // retire first: a result leaving now belongs to an earlier item
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("result with no command outstanding");
        end else begin
          want = replies_due.pop_front();
          compare_reply(out_item, want);
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        want = predict_line_cmd(in_item);
        replies_due.push_back(want);
        if (want.start_request) starts++;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SCREEN_W) scr_w = cfg_data;
        else scr_h = cfg_data;
      end
    end
    pending <= replies_due.size();
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import ldb_pkg::*;

  localparam logic [2:0] CMD_UNKNOWN_LO = 3'd6;
  localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int NUM_PHASES   = 4;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_item_t               in_item   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_item;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_SCREEN_W;
  logic [COORD_W-1:0]     cfg_data  = '0;

  int   fail_count;
  int   pending;
  int   checked;
  int   starts;
  int   send_idle_pct = 0;
  int   rcv_idle_pct  = 0;
  logic long_hold     = 1'b0;
  int   held          = 0;
  int   cycle_count   = 0;
  int   items_sent    = 0;
  int   cur_w         = int'(SCREEN_W_RESET);
  int   cur_h         = int'(SCREEN_H_RESET);

  int ph_w     [NUM_PHASES] = '{4095, 1, 640, 320};
  int ph_h     [NUM_PHASES] = '{4095, 1, 480, 240};
  int ph_items [NUM_PHASES] = '{250, 150, 200, 380};
  int ph_sidle [NUM_PHASES] = '{32, 79, 79, 0};
  int ph_ridle [NUM_PHASES] = '{79, 32, 32, 0};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  line_double_buffer_dma_manager uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  line_cmd_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .starts     (starts)
  );

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (long_hold && held < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      held      <= held + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      if (!long_hold) held <= 0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("line_double_buffer_dma_manager regression: fail");
      $finish;
    end
  end

  function automatic in_item_t line_cmd(input logic [2:0] cmd, input logic slot,
                                        input int x, input int y, input int w,
                                        input logic [1:0] status, input logic start_ok);
    in_item_t it;
    it.command    = cmd;
    it.slot       = slot;
    it.x          = COORD_W'(x);
    it.y          = COORD_W'(y);
    it.width      = COORD_W'(w);
    it.dma_status = status;
    it.start_ok   = start_ok;
    return it;
  endfunction

  function automatic in_item_t random_line_cmd();
    in_item_t it;
    int       pick;
    int       w;
    int       st;
    it.slot       = 1'($urandom);
    it.x          = COORD_W'($urandom);
    it.y          = COORD_W'($urandom);
    it.width      = COORD_W'($urandom);
    it.dma_status = 2'($urandom);
    it.start_ok   = 1'($urandom);
    pick          = $urandom_range(0, 99);
    if (pick < 18) begin
      it.command = CMD_ACQUIRE;
    end else if (pick < 45) begin
      it.command = CMD_COMMIT;
      // mostly windows that fit the current screen
      if ($urandom_range(0, 9) < 8) begin
        w        = $urandom_range(1, cur_w);
        it.width = COORD_W'(w);
        it.x     = COORD_W'($urandom_range(0, cur_w - w));
        it.y     = COORD_W'($urandom_range(0, cur_h - 1));
      end
    end else if (pick < 52) begin
      it.command = CMD_CANCEL;
    end else if (pick < 85) begin
      it.command = CMD_SERVICE;
      st = $urandom_range(0, 9);
      if (st < 3) it.dma_status = DMA_BUSY;
      else if (st < 7) it.dma_status = DMA_DONE;
      else if (st < 9) it.dma_status = DMA_FAIL;
      else it.dma_status = DMA_RSVD;
      it.start_ok = ($urandom_range(0, 9) != 0);
    end else if (pick < 90) begin
      it.command = CMD_INIT;
    end else if (pick < 95) begin
      it.command = CMD_CLR_ERR;
    end else begin
      it.command = 3'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
    end
    return it;
  endfunction

  // valid stays high after an accept; the next call either idles or replaces the item
  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent++;
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_screen(input int w, input int h);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SCREEN_W;
    cfg_data  <= COORD_W'(w);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_index <= REG_SCREEN_H;
    cfg_data  <= COORD_W'(h);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  // runs on the reset screen of 320 x 240
  task automatic run_directed();
    send_item(line_cmd(CMD_INIT, 1'b0, 0, 0, 0, DMA_BUSY, 1'b0));
    send_item(line_cmd(CMD_ACQUIRE, 1'b0, 0, 0, 0, DMA_BUSY, 1'b0));
    send_item(line_cmd(CMD_ACQUIRE, 1'b0, 0, 0, 0, DMA_BUSY, 1'b0));
    // both slots taken
    send_item(line_cmd(CMD_ACQUIRE, 1'b0, 0, 0, 0, DMA_BUSY, 1'b0));
    // rejected windows: zero width, too wide, x past the edge, y off screen
    send_item(line_cmd(CMD_COMMIT, 1'b0, 0, 0, 0, DMA_BUSY, 1'b0));
    send_item(line_cmd(CMD_COMMIT, 1'b0, 0, 0, 4095, DMA_BUSY, 1'b0));
    send_item(line_cmd(CMD_COMMIT, 1'b0, 4095, 0, 1, DMA_BUSY, 1'b0));
    send_item(line_cmd(CMD_COMMIT, 1'b0, 0, 4095, 10, DMA_BUSY, 1'b0));
    send_item(line_cmd(CMD_COMMIT, 1'b0, 0, 239, 320, DMA_BUSY, 1'b0));
    // slot 0 is ready now, so neither commit nor cancel applies
    send_item(line_cmd(CMD_COMMIT, 1'b0, 0, 0, 1, DMA_BUSY, 1'b0));
    send_item(line_cmd(CMD_CANCEL, 1'b0, 0, 0, 0, DMA_BUSY, 1'b0));
    send_item(line_cmd(CMD_COMMIT, 1'b1, 319, 0, 1, DMA_BUSY, 1'b0));
    // start refused: slot 0 dropped, error sticks
    send_item(line_cmd(CMD_SERVICE, 1'b0, 0, 0, 0, DMA_BUSY, 1'b0));
    send_item(line_cmd(CMD_CLR_ERR, 1'b0, 0, 0, 0, DMA_BUSY, 1'b0));
    send_item(line_cmd(CMD_SERVICE, 1'b0, 0, 0, 0, DMA_BUSY, 1'b1));
    // reserved status counts as busy
    send_item(line_cmd(CMD_SERVICE, 1'b0, 0, 0, 0, DMA_RSVD, 1'b1));
    send_item(line_cmd(CMD_INIT, 1'b0, 0, 0, 0, DMA_BUSY, 1'b0));
    send_item(line_cmd(CMD_SERVICE, 1'b0, 0, 0, 0, DMA_DONE, 1'b1));
    send_item(line_cmd(CMD_ACQUIRE, 1'b0, 0, 0, 0, DMA_BUSY, 1'b0));
    send_item(line_cmd(CMD_COMMIT, 1'b0, 0, 0, 320, DMA_BUSY, 1'b0));
    send_item(line_cmd(CMD_SERVICE, 1'b0, 0, 0, 0, DMA_DONE, 1'b1));
    send_item(line_cmd(CMD_SERVICE, 1'b0, 0, 0, 0, DMA_FAIL, 1'b1));
    send_item(line_cmd(CMD_UNKNOWN_LO, 1'b1, 4095, 4095, 4095, DMA_RSVD, 1'b1));
    send_item(line_cmd(CMD_UNKNOWN_HI, 1'b0, 0, 0, 0, DMA_BUSY, 1'b0));
    send_item(line_cmd(CMD_ACQUIRE, 1'b0, 0, 0, 0, DMA_BUSY, 1'b0));
    send_item(line_cmd(CMD_CANCEL, 1'b0, 0, 0, 0, DMA_BUSY, 1'b0));
    send_item(line_cmd(CMD_CANCEL, 1'b1, 0, 0, 0, DMA_BUSY, 1'b0));
    send_item(line_cmd(CMD_INIT, 1'b0, 0, 0, 0, DMA_DONE, 1'b0));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 32;
    rcv_idle_pct  <= 79;
    run_directed();
    for (int p = 0; p < NUM_PHASES; p++) begin
      stop_sending();
      wait_quiet();
      set_screen(ph_w[p], ph_h[p]);
      send_idle_pct = ph_sidle[p];
      rcv_idle_pct  <= ph_ridle[p];
      // back up the block with a long output stall
      if (p == NUM_PHASES - 1) long_hold <= 1'b1;
      for (int n = 0; n < ph_items[p]; n++) begin
        if (p == 2 && n == ph_items[p] / 2) begin
          stop_sending();
          wait_quiet();
        end
        if (p == NUM_PHASES - 1 && n == 40) long_hold <= 1'b0;
        send_item(random_line_cmd());
      end
    end
    stop_sending();
    wait_quiet();
    $display("Sent %0d commands over %0d screen settings; %0d results checked.",
             items_sent, NUM_PHASES + 1, checked);
    $display("Line transfers started: %0d; mismatches: %0d.", starts, fail_count);
    if (fail_count == 0) begin
      $display("line_double_buffer_dma_manager regression: pass");
    end else begin
      $display("line_double_buffer_dma_manager regression: fail");
    end
    $finish;
  end

endmodule
